// ===== design/fall_detector_three_stage_macros.svh =====
// assertion helpers shared by the fall detector rtl
`ifndef FALL_DETECTOR_THREE_STAGE_MACROS_SVH
`define FALL_DETECTOR_THREE_STAGE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define FDT_ASSERT_IMPLY(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FDT_ASSERT_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fdt_pkg.sv =====
package fdt_pkg;

   // sample width and the widths that follow from it
   localparam int SAMPLE_W  = 16;
   localparam int ACC_W     = 2 * SAMPLE_W + 2;
   localparam int HI_W      = SAMPLE_W + 2;
   localparam int STEP_W    = $clog2(SAMPLE_W);
   localparam int THR_W     = 48;
   localparam int CMP_W     = (ACC_W + 14 > THR_W) ? ACC_W + 14 : THR_W;
   localparam int SCALE_W   = 29;
   localparam int BASE_W    = 11;
   localparam int SQ_W      = 2 * BASE_W;
   localparam int THR_N     = 5;
   localparam int THR_IDX_W = $clog2(THR_N);
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;

   // 16384^2 and 13107^2
   localparam logic [SCALE_W-1:0] G_SQ   = SCALE_W'(268435456);
   localparam logic [SCALE_W-1:0] DPS_SQ = SCALE_W'(171793449);

   // threshold slots
   localparam logic [THR_IDX_W-1:0] THR_LOW   = THR_IDX_W'(0);
   localparam logic [THR_IDX_W-1:0] THR_HIGH  = THR_IDX_W'(1);
   localparam logic [THR_IDX_W-1:0] THR_RMIN  = THR_IDX_W'(2);
   localparam logic [THR_IDX_W-1:0] THR_RMAX  = THR_IDX_W'(3);
   localparam logic [THR_IDX_W-1:0] THR_STILL = THR_IDX_W'(4);

   // register indexes
   localparam logic [2:0] REG_LOW_IMPACT     = 3'd0;
   localparam logic [2:0] REG_HIGH_IMPACT    = 3'd1;
   localparam logic [2:0] REG_ROTATE_MIN     = 3'd2;
   localparam logic [2:0] REG_ROTATE_MAX     = 3'd3;
   localparam logic [2:0] REG_SETTLE_MAX     = 3'd4;
   localparam logic [2:0] REG_STAGE_TIMEOUT  = 3'd5;
   localparam logic [2:0] REG_SETTLE_SAMPLES = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
   } fdt_req_type;

   typedef struct packed {
      logic fall_detected;
      logic stage_one_armed;
      logic stage_two_armed;
      logic stage_three_armed;
   } fdt_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCALE,
      ST_DECIDE
   } fdt_state_type;

   typedef struct packed {
      logic load;
      logic run;
   } fdt_sq_ctrl_type;

   // magnitude of a two's complement sample, most negative value included
   function automatic logic [SAMPLE_W-1:0] magnitude_of(input logic [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
   endfunction

   function automatic logic [CMP_W-1:0] times_100(input logic [CMP_W-1:0] x);
      return (x << 6) + (x << 5) + (x << 2);
   endfunction

   function automatic logic [CMP_W-1:0] times_10000(input logic [CMP_W-1:0] x);
      return (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4);
   endfunction

endpackage

// ===== design/fdt_sqsum.sv =====
module fdt_sqsum (
   input  logic                              clock,
   input  fdt_pkg::fdt_sq_ctrl_type          ctrl,
   input  logic signed [fdt_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [fdt_pkg::SAMPLE_W-1:0] sample_b,
   input  logic signed [fdt_pkg::SAMPLE_W-1:0] sample_c,
   output logic [fdt_pkg::ACC_W-1:0]         sum_sq
);
   import fdt_pkg::*;

   logic [SAMPLE_W-1:0] mag_a_ff, mag_b_ff, mag_c_ff;
   logic [SAMPLE_W-1:0] mult_a_ff, mult_b_ff, mult_c_ff;
   logic [HI_W-1:0]     hi_ff;
   logic [SAMPLE_W-1:0] lo_ff;
   logic [HI_W:0]       step_sum;

   // one multiplier bit of each axis per cycle while run is set, partial sum shifts right
   assign step_sum = {1'b0, hi_ff}
                   + (mult_a_ff[0] ? (HI_W + 1)'(mag_a_ff) : '0)
                   + (mult_b_ff[0] ? (HI_W + 1)'(mag_b_ff) : '0)
                   + (mult_c_ff[0] ? (HI_W + 1)'(mag_c_ff) : '0);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_a_ff  <= magnitude_of(sample_a);
         mag_b_ff  <= magnitude_of(sample_b);
         mag_c_ff  <= magnitude_of(sample_c);
         mult_a_ff <= magnitude_of(sample_a);
         mult_b_ff <= magnitude_of(sample_b);
         mult_c_ff <= magnitude_of(sample_c);
         hi_ff     <= '0;
         lo_ff     <= '0;
      end else if (ctrl.run) begin
         mult_a_ff <= mult_a_ff >> 1;
         mult_b_ff <= mult_b_ff >> 1;
         mult_c_ff <= mult_c_ff >> 1;
         hi_ff     <= step_sum[HI_W:1];
         lo_ff     <= {step_sum[0], lo_ff[SAMPLE_W-1:1]};
      end
   end

   assign sum_sq = {hi_ff, lo_ff};

endmodule

// ===== design/fall_detector_three_stage.sv =====
// flow: idle takes a transaction, then square, scale and decide; decide waits for a free
//    response slot, and only idle takes a new one; squaring uses the bit-serial
//    square-and-add units that take one bit of every axis per cycle
// reset: synchronous, active high; clears stage flags, counters, control and the
//    response slot, and loads the register defaults; no memory, no clearing pass
`include "fall_detector_three_stage_macros.svh"

module fall_detector_three_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fdt_pkg::fdt_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fdt_pkg::fdt_rsp_type          rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fdt_pkg::PADDR_W-1:0]   paddr,
   input  logic [fdt_pkg::PDATA_W-1:0]   pwdata,
   output logic [fdt_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import fdt_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

   // configuration registers
   logic [5:0] cfg_low_ff, cfg_high_ff;
   logic [9:0] cfg_rmin_ff, cfg_rmax_ff, cfg_still_ff;
   logic [3:0] cfg_timeout_ff, cfg_settle_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   // control
   fdt_state_type   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   fdt_sq_ctrl_type sq_ctrl;
   logic            out_free;
   logic            scale_en;
   logic            decide_fire;

   // datapath
   logic [ACC_W-1:0]     acc_sum, gyro_sum;
   logic [BASE_W-1:0]    thr_base;
   logic [SQ_W-1:0]      thr_sq_ff;
   logic [THR_IDX_W-1:0] thr_wr_idx;
   logic [SCALE_W-1:0]   thr_scale;
   logic                 thr_wr_en;
   logic [THR_W-1:0]     thr_ff [THR_N];
   logic [CMP_W-1:0]     lhs_acc_ff, lhs_gyro_ff;
   logic                 low_impact, high_impact, rate_min_ok, rate_max_ok, still;

   // detector state
   logic       free_fall_armed_ff, free_fall_armed_in;
   logic       impact_armed_ff, impact_armed_in;
   logic       rotation_armed_ff, rotation_armed_in;
   logic [3:0] free_fall_count_ff, free_fall_count_in;
   logic [3:0] impact_count_ff, impact_count_in;
   logic [3:0] settle_count_ff, settle_count_in;
   logic       fall;

   // response slot
   logic        rsp_valid_ff;
   fdt_rsp_type rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // register port: pready tied high, write lands on the access phase
   // ---------------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff     <= 6'd2;
         cfg_high_ff    <= 6'd12;
         cfg_rmin_ff    <= 10'd30;
         cfg_rmax_ff    <= 10'd400;
         cfg_still_ff   <= 10'd10;
         cfg_timeout_ff <= 4'd6;
         cfg_settle_ff  <= 4'd10;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOW_IMPACT:     cfg_low_ff     <= pwdata[5:0];
            REG_HIGH_IMPACT:    cfg_high_ff    <= pwdata[5:0];
            REG_ROTATE_MIN:     cfg_rmin_ff    <= pwdata[9:0];
            REG_ROTATE_MAX:     cfg_rmax_ff    <= pwdata[9:0];
            REG_SETTLE_MAX:     cfg_still_ff   <= pwdata[9:0];
            REG_STAGE_TIMEOUT:  cfg_timeout_ff <= pwdata[3:0];
            REG_SETTLE_SAMPLES: cfg_settle_ff  <= pwdata[3:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LOW_IMPACT:     prdata = PDATA_W'(cfg_low_ff);
         REG_HIGH_IMPACT:    prdata = PDATA_W'(cfg_high_ff);
         REG_ROTATE_MIN:     prdata = PDATA_W'(cfg_rmin_ff);
         REG_ROTATE_MAX:     prdata = PDATA_W'(cfg_rmax_ff);
         REG_SETTLE_MAX:     prdata = PDATA_W'(cfg_still_ff);
         REG_STAGE_TIMEOUT:  prdata = PDATA_W'(cfg_timeout_ff);
         REG_SETTLE_SAMPLES: prdata = PDATA_W'(cfg_settle_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // sequencer: idle -> square (one sample bit per cycle) -> scale -> decide
   // ---------------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: if (step_ff == STEP_LAST) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DECIDE;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      sq_ctrl.run = 1'b0;
      scale_en    = 1'b0;
      decide_fire = 1'b0;
      step_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
         end
         ST_SQUARE: begin
            sq_ctrl.run = 1'b1;
            step_in     = step_ff + STEP_W'(1);
         end
         ST_SCALE: begin
            scale_en = 1'b1;
         end
         ST_DECIDE: begin
            decide_fire = out_free;
         end
         default: ;
      endcase
      sq_ctrl.load = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // squared magnitudes, one serial unit per sensor
   // ---------------------------------------------------------------------------------
   fdt_sqsum u_acc_sq (
      .clock    (clock),
      .ctrl     (sq_ctrl),
      .sample_a (req_data.accel_x),
      .sample_b (req_data.accel_y),
      .sample_c (req_data.accel_z),
      .sum_sq   (acc_sum)
   );

   fdt_sqsum u_gyro_sq (
      .clock    (clock),
      .ctrl     (sq_ctrl),
      .sample_a (req_data.gyro_x),
      .sample_b (req_data.gyro_y),
      .sample_c (req_data.gyro_z),
      .sum_sq   (gyro_sum)
   );

   // ---------------------------------------------------------------------------------
   // thresholds: built during the first squaring cycles, one slot per cycle
   //    square the base, then scale by counts-per-unit squared
   // ---------------------------------------------------------------------------------
   always_comb begin
      case (step_ff[THR_IDX_W-1:0])
         THR_LOW:   thr_base = BASE_W'(cfg_low_ff) + BASE_W'(1);
         THR_HIGH:  thr_base = BASE_W'(cfg_high_ff);
         THR_RMIN:  thr_base = BASE_W'(cfg_rmin_ff);
         THR_RMAX:  thr_base = BASE_W'(cfg_rmax_ff) + BASE_W'(1);
         THR_STILL: thr_base = BASE_W'(cfg_still_ff) + BASE_W'(1);
         default:   thr_base = '0;
      endcase
   end

   assign thr_wr_idx = THR_IDX_W'(step_ff - STEP_W'(1));
   assign thr_wr_en  = (state_ff == ST_SQUARE) && (step_ff != '0) &&
                       (step_ff <= STEP_W'(THR_N));
   assign thr_scale  = (thr_wr_idx < THR_RMIN) ? G_SQ : DPS_SQ;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQUARE) begin
         thr_sq_ff <= SQ_W'(thr_base) * SQ_W'(thr_base);
      end
      if (thr_wr_en) begin
         thr_ff[thr_wr_idx] <= THR_W'(thr_sq_ff) * THR_W'(thr_scale);
      end
   end

   // left sides of the compares: 100 * accel sum, 10000 * gyro sum
   always_ff @(posedge clock) begin
      if (scale_en) begin
         lhs_acc_ff  <= times_100(CMP_W'(acc_sum));
         lhs_gyro_ff <= times_10000(CMP_W'(gyro_sum));
      end
   end

   assign low_impact  = lhs_acc_ff  <  CMP_W'(thr_ff[THR_LOW]);
   assign high_impact = lhs_acc_ff  >= CMP_W'(thr_ff[THR_HIGH]);
   assign rate_min_ok = lhs_gyro_ff >= CMP_W'(thr_ff[THR_RMIN]);
   assign rate_max_ok = lhs_gyro_ff <  CMP_W'(thr_ff[THR_RMAX]);
   assign still       = lhs_gyro_ff <  CMP_W'(thr_ff[THR_STILL]);

   // ---------------------------------------------------------------------------------
   // stage update, in order: free fall, impact, rotation window, settle, timeouts
   // ---------------------------------------------------------------------------------
   always_comb begin
      free_fall_armed_in = free_fall_armed_ff;
      impact_armed_in    = impact_armed_ff;
      rotation_armed_in  = rotation_armed_ff;
      free_fall_count_in = free_fall_count_ff;
      impact_count_in    = impact_count_ff;
      settle_count_in    = settle_count_ff;
      fall               = 1'b0;

      // free fall arms only while impact is idle
      if (low_impact && !impact_armed_ff) free_fall_armed_in = 1'b1;

      if (free_fall_armed_in) begin
         free_fall_count_in = free_fall_count_ff + 4'd1;
         if (high_impact) begin
            impact_armed_in    = 1'b1;
            free_fall_armed_in = 1'b0;
            free_fall_count_in = '0;
         end
      end

      if (impact_armed_in) begin
         impact_count_in = impact_count_ff + 4'd1;
         if (rate_min_ok && rate_max_ok) begin
            rotation_armed_in = 1'b1;
            impact_armed_in   = 1'b0;
            impact_count_in   = '0;
         end
      end

      // settle then check stillness
      if (rotation_armed_in) begin
         settle_count_in = settle_count_ff + 4'd1;
         if (settle_count_in >= cfg_settle_ff) begin
            fall              = still;
            rotation_armed_in = 1'b0;
            settle_count_in   = '0;
         end
      end

      // impact timeout first, then free fall
      if (impact_count_in >= cfg_timeout_ff) begin
         impact_armed_in = 1'b0;
         impact_count_in = '0;
      end
      if (free_fall_count_in >= cfg_timeout_ff) begin
         free_fall_armed_in = 1'b0;
         free_fall_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_fall_armed_ff <= 1'b0;
         impact_armed_ff    <= 1'b0;
         rotation_armed_ff  <= 1'b0;
         free_fall_count_ff <= '0;
         impact_count_ff    <= '0;
         settle_count_ff    <= '0;
      end else if (decide_fire) begin
         free_fall_armed_ff <= free_fall_armed_in;
         impact_armed_ff    <= impact_armed_in;
         rotation_armed_ff  <= rotation_armed_in;
         free_fall_count_ff <= free_fall_count_in;
         impact_count_ff    <= impact_count_in;
         settle_count_ff    <= settle_count_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // response slot, one transaction deep
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decide_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_fire) begin
         rsp_data_ff.fall_detected     <= fall;
         rsp_data_ff.stage_one_armed   <= free_fall_armed_in;
         rsp_data_ff.stage_two_armed   <= impact_armed_in;
         rsp_data_ff.stage_three_armed <= rotation_armed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------
   `FDT_ASSERT_IMPLY(a_fall_impact_excl, reset, free_fall_armed_ff, !impact_armed_ff,
      "free fall and impact armed together")
   `FDT_ASSERT_IMPLY(a_ff_count_armed, reset, free_fall_count_ff != '0, free_fall_armed_ff,
      "free fall count running while disarmed")
   `FDT_ASSERT_IMPLY(a_settle_count_armed, reset, settle_count_ff != '0, rotation_armed_ff,
      "settle count running while disarmed")
   `FDT_ASSERT_NEXT(a_square_length, reset, state_ff == ST_SQUARE && step_ff != STEP_LAST,
      state_ff == ST_SQUARE, "squaring ended before the last sample bit")

endmodule

// ===== sim/fall_detector_three_stage_tb.sv =====
`timescale 1ns / 100ps

module fall_detector_three_stage_tb;
   import fdt_pkg::*;

   // run shape
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake of any kind
   localparam int DRAIN_CYCLES   = 40;     // wait after the drain for stray results
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 144;    // random transactions per register setting
   localparam int MAX_GAP        = 60;

   // register index past the end of the map, writes must be ignored
   localparam logic [2:0] REG_UNUSED = 3'd7;

   // 16384^2 counts per g squared, 13107^2 for the rate scale
   localparam logic [63:0] ACCEL_SCALE_SQ = 64'd268435456;
   localparam logic [63:0] RATE_SCALE_SQ  = 64'd171793449;

   // flag patterns for rows that can be read off directly
   localparam fdt_rsp_type FLAGS_NONE    = 4'b0000;
   localparam fdt_rsp_type FLAGS_STAGE_1 = 4'b0100;
   localparam fdt_rsp_type FLAGS_STAGE_2 = 4'b0010;

   // clock, reset and block ports
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   fdt_req_type         req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   fdt_rsp_type         rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [PADDR_W-1:0]  paddr     = '0;
   logic [PDATA_W-1:0]  pwdata    = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // idling knobs, percent of cycles
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;

   // bookkeeping
   int mismatches    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int falls_seen    = 0;
   int settings_used = 0;
   int idle_cycles   = 0;

   // flags still owed by the block, oldest first
   fdt_rsp_type fall_flags_due[$];

   // directed probe rows
   typedef struct {
      fdt_req_type sample;
      bit          typed;
      fdt_rsp_type flags;
   } probe_row_type;
   probe_row_type probe_table[$];

   // shadow copy of the registers
   logic [5:0] cfg_low;
   logic [5:0] cfg_high;
   logic [9:0] cfg_rmin;
   logic [9:0] cfg_rmax;
   logic [9:0] cfg_still;
   logic [3:0] cfg_timeout;
   logic [3:0] cfg_settle;

   // shadow copy of the detector state
   logic       ff_armed;
   logic       imp_armed;
   logic       rot_armed;
   logic [3:0] ff_cnt;
   logic [3:0] imp_cnt;
   logic [3:0] settle_cnt;

   fall_detector_three_stage dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // detector prediction
   // ---------------------------------------------------------------------

   function automatic void model_reset();
      cfg_low     = 6'd2;
      cfg_high    = 6'd12;
      cfg_rmin    = 10'd30;
      cfg_rmax    = 10'd400;
      cfg_still   = 10'd10;
      cfg_timeout = 4'd6;
      cfg_settle  = 4'd10;
      ff_armed    = 1'b0;
      imp_armed   = 1'b0;
      rot_armed   = 1'b0;
      ff_cnt      = '0;
      imp_cnt     = '0;
      settle_cnt  = '0;
   endfunction

   function automatic logic [63:0] square_of_axis(input logic signed [SAMPLE_W-1:0] v);
      longint w;
      w = v;
      return w * w;
   endfunction

   // floor(sqrt(g) / 131.07) >= r
   function automatic bit rate_reaches(input logic [63:0] g, input logic [9:0] r);
      logic [63:0] rr;
      rr = 64'(r);
      return 64'd10000 * g >= rr * rr * RATE_SCALE_SQ;
   endfunction

   // floor(sqrt(g) / 131.07) <= r
   function automatic bit rate_within(input logic [63:0] g, input logic [9:0] r);
      logic [63:0] rr;
      rr = 64'(r) + 64'd1;
      return 64'd10000 * g < rr * rr * RATE_SCALE_SQ;
   endfunction

   // advances the shadow state by one sample and returns the flags it produces
   function automatic fdt_rsp_type predict_fall_flags(input fdt_req_type s);
      logic [63:0] accel_sq;
      logic [63:0] rate_sq;
      logic [63:0] lo_bound;
      logic [63:0] hi_bound;
      bit          low_hit;
      bit          high_hit;
      bit          fall;
      fdt_rsp_type flags;
      accel_sq = square_of_axis($signed(s.accel_x)) + square_of_axis($signed(s.accel_y))
               + square_of_axis($signed(s.accel_z));
      rate_sq  = square_of_axis($signed(s.gyro_x)) + square_of_axis($signed(s.gyro_y))
               + square_of_axis($signed(s.gyro_z));
      lo_bound = 64'(cfg_low) + 64'd1;
      hi_bound = 64'(cfg_high);
      low_hit  = 64'd100 * accel_sq < lo_bound * lo_bound * ACCEL_SCALE_SQ;
      high_hit = 64'd100 * accel_sq >= hi_bound * hi_bound * ACCEL_SCALE_SQ;
      fall     = 1'b0;

      // free fall arms stage one unless an impact is already pending
      if (low_hit && !imp_armed) begin
         ff_armed = 1'b1;
      end
      // impact while in free fall hands over to stage two
      if (ff_armed) begin
         ff_cnt = ff_cnt + 4'd1;
         if (high_hit) begin
            imp_armed = 1'b1;
            ff_armed  = 1'b0;
            ff_cnt    = '0;
         end
      end
      // rotation inside the window hands over to stage three
      if (imp_armed) begin
         imp_cnt = imp_cnt + 4'd1;
         if (rate_reaches(rate_sq, cfg_rmin) && rate_within(rate_sq, cfg_rmax)) begin
            rot_armed = 1'b1;
            imp_armed = 1'b0;
            imp_cnt   = '0;
         end
      end
      // settle, then look for stillness
      if (rot_armed) begin
         settle_cnt = settle_cnt + 4'd1;
         if (settle_cnt >= cfg_settle) begin
            fall       = rate_within(rate_sq, cfg_still);
            rot_armed  = 1'b0;
            settle_cnt = '0;
         end
      end
      // timeouts, stage two first
      if (imp_cnt >= cfg_timeout) begin
         imp_armed = 1'b0;
         imp_cnt   = '0;
      end
      if (ff_cnt >= cfg_timeout) begin
         ff_armed = 1'b0;
         ff_cnt   = '0;
      end

      flags.fall_detected     = fall;
      flags.stage_one_armed   = ff_armed;
      flags.stage_two_armed   = imp_armed;
      flags.stage_three_armed = rot_armed;
      return flags;
   endfunction

   function automatic void store_setting(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         REG_LOW_IMPACT: begin
            cfg_low = v[5:0];
         end
         REG_HIGH_IMPACT: begin
            cfg_high = v[5:0];
         end
         REG_ROTATE_MIN: begin
            cfg_rmin = v[9:0];
         end
         REG_ROTATE_MAX: begin
            cfg_rmax = v[9:0];
         end
         REG_SETTLE_MAX: begin
            cfg_still = v[9:0];
         end
         REG_STAGE_TIMEOUT: begin
            cfg_timeout = v[3:0];
         end
         REG_SETTLE_SAMPLES: begin
            cfg_settle = v[3:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [PDATA_W-1:0] setting_of(input logic [2:0] idx);
      case (idx)
         REG_LOW_IMPACT:     return PDATA_W'(cfg_low);
         REG_HIGH_IMPACT:    return PDATA_W'(cfg_high);
         REG_ROTATE_MIN:     return PDATA_W'(cfg_rmin);
         REG_ROTATE_MAX:     return PDATA_W'(cfg_rmax);
         REG_SETTLE_MAX:     return PDATA_W'(cfg_still);
         REG_STAGE_TIMEOUT:  return PDATA_W'(cfg_timeout);
         REG_SETTLE_SAMPLES: return PDATA_W'(cfg_settle);
         default:            return '0;
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endfunction

   // ---------------------------------------------------------------------
   // sample builders
   // ---------------------------------------------------------------------

   function automatic fdt_req_type sample_of(input int ax, input int ay, input int az,
                                             input int gx, input int gy, input int gz);
      fdt_req_type s;
      s.accel_x = SAMPLE_W'(ax);
      s.accel_y = SAMPLE_W'(ay);
      s.accel_z = SAMPLE_W'(az);
      s.gyro_x  = SAMPLE_W'(gx);
      s.gyro_y  = SAMPLE_W'(gy);
      s.gyro_z  = SAMPLE_W'(gz);
      return s;
   endfunction

   // clamp to the positive range and pick a random sign
   function automatic logic signed [SAMPLE_W-1:0] signed_axis(input int mag);
      int m;
      m = (mag > 32767) ? 32767 : mag;
      return $urandom_range(1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
   endfunction

   // spreads a target level evenly over the three axes, so one axis carries 1/sqrt(3)
   function automatic fdt_req_type sample_near(input int accel_tenths, input int rate_dps);
      fdt_req_type s;
      int am;
      int gm;
      am = accel_tenths * 945;   // 1638.4 counts per tenth g, times 0.577
      gm = rate_dps * 76;        // 131.07 counts per dps, times 0.577
      s.accel_x = signed_axis(am + $urandom_range(0, 100));
      s.accel_y = signed_axis(am + $urandom_range(0, 100));
      s.accel_z = signed_axis(am + $urandom_range(0, 100));
      s.gyro_x  = signed_axis(gm + $urandom_range(0, 20));
      s.gyro_y  = signed_axis(gm + $urandom_range(0, 20));
      s.gyro_z  = signed_axis(gm + $urandom_range(0, 20));
      return s;
   endfunction

   function automatic void add_probe(input fdt_req_type s, input bit typed,
                                     input fdt_rsp_type flags);
      probe_row_type row;
      row.sample = s;
      row.typed  = typed;
      row.flags  = flags;
      probe_table.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // drivers, all updates land on the rising edge
   // ---------------------------------------------------------------------

   // one sample transaction; valid holds until the handshake
   task automatic send_sample(input fdt_req_type s, input bit typed, input fdt_rsp_type flags);
      int          gap;
      bit          took;
      fdt_rsp_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      // ready is settled by the falling edge, inputs only move on the rising one
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      predicted = predict_fall_flags(s);
      fall_flags_due.push_back(typed ? flags : predicted);
      items_sent++;
   endtask

   // stop sending and wait until every owed result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (fall_flags_due.size() != 0);
   endtask

   // one apb transfer, setup then access; the bus is left selected for a back-to-back
   task automatic csr_access(input logic [2:0] idx, input bit is_write,
                             input logic [PDATA_W-1:0] v, output logic [PDATA_W-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      rd = prdata;
      @(posedge clock);
   endtask

   // write, mirror, then read back
   task automatic set_register(input logic [2:0] idx, input int v);
      logic [PDATA_W-1:0] rd;
      csr_access(idx, 1'b1, PDATA_W'(v), rd);
      store_setting(idx, PDATA_W'(v));
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== setting_of(idx)) begin
         note_mismatch($sformatf("register %0d read back %0h, expected %0h",
                                 idx, rd, setting_of(idx)));
      end
   endtask

   // free fall, impact, rotation, then a settle stretch that is mostly still
   task automatic send_fall_sequence();
      int n;
      int rate;
      n = $urandom_range(1, 3);
      repeat (n) begin
         send_sample(sample_near($urandom_range(0, cfg_low), $urandom_range(0, 450)), 1'b0,
                     FLAGS_NONE);
      end
      send_sample(sample_near($urandom_range(cfg_high, cfg_high + 10), $urandom_range(0, 450)),
                  1'b0, FLAGS_NONE);
      repeat ($urandom_range(0, 2)) begin
         send_sample(sample_near($urandom_range(8, 11), $urandom_range(0, 450)), 1'b0,
                     FLAGS_NONE);
      end
      rate = (cfg_rmin <= cfg_rmax) ? $urandom_range(cfg_rmin, cfg_rmax)
                                    : $urandom_range(0, 450);
      send_sample(sample_near($urandom_range(8, 11), rate), 1'b0, FLAGS_NONE);
      n = ((cfg_settle > 0) ? cfg_settle - 1 : 0) + $urandom_range(0, 2);
      repeat (n) begin
         rate = ($urandom_range(99) < 80) ? $urandom_range(0, cfg_still)
                                          : $urandom_range(0, 450);
         send_sample(sample_near($urandom_range(8, 11), rate), 1'b0, FLAGS_NONE);
      end
   endtask

   // raw bit patterns and loose samples that break sequences
   task automatic send_noise();
      fdt_req_type s;
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(1)) begin
            s = {$urandom(), $urandom(), $urandom()};
         end else begin
            s = sample_near($urandom_range(0, 40), $urandom_range(0, 450));
         end
         send_sample(s, 1'b0, FLAGS_NONE);
      end
   endtask

   // one register setting plus a random stretch under one idling pattern
   task automatic run_phase(input int src_pct, input int sink_pct,
                            input int lo, input int hi, input int rmin, input int rmax,
                            input int still, input int tmo, input int settle);
      logic [PDATA_W-1:0] rd;
      int start;
      bit paused;
      wait_for_drain();
      set_register(REG_LOW_IMPACT, lo);
      set_register(REG_HIGH_IMPACT, hi);
      set_register(REG_ROTATE_MIN, rmin);
      set_register(REG_ROTATE_MAX, rmax);
      set_register(REG_SETTLE_MAX, still);
      set_register(REG_STAGE_TIMEOUT, tmo);
      set_register(REG_SETTLE_SAMPLES, settle);
      // out-of-map write, must leave every register alone
      csr_access(REG_UNUSED, 1'b1, $urandom(), rd);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < PHASE_ITEMS) begin
         // halfway through, hold off until the pipe is empty
         if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 70) begin
            send_fall_sequence();
         end else begin
            send_noise();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   // random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // compare each result transaction with the oldest owed flags
   always @(posedge clock) begin : check_flags
      fdt_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.fall_detected === 1'b1) begin
            falls_seen++;
         end
         if (fall_flags_due.size() == 0) begin
            note_mismatch($sformatf("result %b with nothing outstanding", rsp_data));
         end else begin
            want = fall_flags_due.pop_front();
            if (rsp_data.fall_detected !== want.fall_detected ||
                rsp_data.stage_one_armed !== want.stage_one_armed ||
                rsp_data.stage_two_armed !== want.stage_two_armed ||
                rsp_data.stage_three_armed !== want.stage_three_armed) begin
               note_mismatch($sformatf(
                  "result %0d: expected fall=%b s1=%b s2=%b s3=%b, got fall=%b s1=%b s2=%b s3=%b",
                  results_seen, want.fall_detected, want.stage_one_armed,
                  want.stage_two_armed, want.stage_three_armed, rsp_data.fall_detected,
                  rsp_data.stage_one_armed, rsp_data.stage_two_armed,
                  rsp_data.stage_three_armed));
            end
         end
      end
   end

   // watchdog on any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   initial begin
      model_reset();

      // directed probes under reset settings
      // quiet sample: free fall arms stage one
      add_probe(sample_of(0, 0, 0, 0, 0, 0), 1'b1, FLAGS_STAGE_1);
      // most negative acceleration on every axis: impact
      add_probe(sample_of(-32768, -32768, -32768, 0, 0, 0), 1'b1, FLAGS_STAGE_2);
      // 100 dps rotation inside the window
      add_probe(sample_of(0, 0, 16384, 13100, 0, 0), 1'b0, FLAGS_NONE);
      // lying still through the settle count, the last one confirms
      repeat (9) add_probe(sample_of(0, 0, 16384, 0, 0, 0), 1'b0, FLAGS_NONE);
      // full-scale extremes with nothing armed
      add_probe(sample_of(32767, 32767, 32767, -32768, -32768, -32768), 1'b1, FLAGS_NONE);
      add_probe(sample_of(-32768, -32768, -32768, 32767, 32767, 32767), 1'b1, FLAGS_NONE);
      // alternating bit patterns
      add_probe(sample_of(21845, -21846, 21845, -21846, 21845, -21846), 1'b0, FLAGS_NONE);
      // free fall held past the stage timeout, then rearmed
      repeat (7) add_probe(sample_of(0, 0, 0, 0, 0, 0), 1'b0, FLAGS_NONE);
      // impact, rotation above the window, then inside it
      add_probe(sample_of(-32768, -32768, -32768, 0, 0, 0), 1'b0, FLAGS_NONE);
      add_probe(sample_of(0, 0, 16384, -32768, -32768, -32768), 1'b0, FLAGS_NONE);
      add_probe(sample_of(0, 0, 16384, 13100, 0, 0), 1'b0, FLAGS_NONE);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         send_sample(probe_table[i].sample, probe_table[i].typed, probe_table[i].flags);
      end

      // reset values, no idling
      run_phase(0, 0, 2, 12, 30, 400, 10, 6, 10);
      // top of every range but the rotation minimum, which is zero; sender idles
      run_phase(69, 0, 63, 63, 0, 1023, 1023, 15, 15);
      // bottom of every range but timeout and settle count, which are one; receiver stalls
      run_phase(0, 69, 0, 0, 0, 0, 0, 1, 1);
      // zero timeout and zero settle count, both sides idle
      run_phase(27, 27, 2, 12, 30, 400, 10, 0, 0);
      // empty rotation window
      run_phase(0, 0, 2, 12, 500, 100, 10, 6, 10);
      // random settings
      run_phase(69, 0, $urandom_range(0, 10), $urandom_range(5, 25), $urandom_range(0, 150),
                $urandom_range(150, 1023), $urandom_range(0, 60), $urandom_range(1, 15),
                $urandom_range(1, 15));
      run_phase(0, 69, $urandom_range(0, 10), $urandom_range(5, 25), $urandom_range(0, 150),
                $urandom_range(150, 1023), $urandom_range(0, 60), $urandom_range(1, 15),
                $urandom_range(1, 15));
      run_phase(27, 27, $urandom_range(0, 10), $urandom_range(5, 25), $urandom_range(0, 150),
                $urandom_range(150, 1023), $urandom_range(0, 60), $urandom_range(1, 15),
                $urandom_range(1, 15));

      // let everything owed come back, then give stray results a chance to show
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fall_flags_due.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", fall_flags_due.size()));
      end

      $display("covered %0d sample transactions (%0d directed) over %0d register settings",
               items_sent, probe_table.size(), settings_used);
      $display("checked %0d results, %0d confirmed falls, %0d mismatches",
               results_seen, falls_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
